### hdl/qvr_pkg.sv
// Package with the shared constants and types of the quaternion vector rotator.
`default_nettype none

package qvr_pkg;

    // Width of one quaternion component as written through the configuration port.
    localparam int QREG_WIDTH = 16;

    // Width of one stored rotation matrix entry.
    localparam int MAT_WIDTH = 18;

    // Number of entries in the rotation matrix.
    localparam int MAT_ENTRIES = 9;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_QUAT_X = 2'd0,
        CFG_QUAT_Y = 2'd1,
        CFG_QUAT_Z = 2'd2,
        CFG_QUAT_W = 2'd3
    } t_cfg_idx;

    // Step counter of the matrix rebuild sequencer.
    typedef logic [3:0] t_step;

    // One step per component product, then the step that forms the entries.
    localparam t_step P_XX = 4'd0;
    localparam t_step P_YY = 4'd1;
    localparam t_step P_ZZ = 4'd2;
    localparam t_step P_XY = 4'd3;
    localparam t_step P_XZ = 4'd4;
    localparam t_step P_YZ = 4'd5;
    localparam t_step P_WX = 4'd6;
    localparam t_step P_WY = 4'd7;
    localparam t_step P_WZ = 4'd8;
    localparam t_step P_DONE = 4'd9;

endpackage

`default_nettype wire

### hdl/qvr_vec_if.sv
// Interface carrying one input vector request.
`default_nettype none

interface qvr_vec_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;
    logic signed [COORD_WIDTH-1:0] vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

`default_nettype wire

### hdl/qvr_rot_if.sv
// Interface carrying one rotated vector request.
`default_nettype none

interface qvr_rot_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] rot_x;
    logic signed [COORD_WIDTH-1:0] rot_y;
    logic signed [COORD_WIDTH-1:0] rot_z;
    logic                          saturated;

    modport source (
        output valid, output rot_x, output rot_y, output rot_z, output saturated, input ready
    );
    modport sink (
        input valid, input rot_x, input rot_y, input rot_z, input saturated, output ready
    );
endinterface

`default_nettype wire

### hdl/quaternion_vector_rotate_core.sv
// Quaternion vector rotator: matrix rebuild sequencer and three-stage rotation pipeline.
// An accepted input request passes the product, row-sum and output registers in turn.
// Throughput: one vector per cycle; the whole pipeline holds while the output is stalled.
// A quaternion write starts a matrix rebuild on one shared multiplier, during which
// no input request is accepted. Synchronous active-low reset loads the identity
// quaternion and the identity matrix and empties the pipeline.
`default_nettype none

module quaternion_vector_rotate_core #(
    parameter int COORD_WIDTH    = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire qvr_pkg::t_cfg_idx                   i_cfg_idx,
    input  wire logic [qvr_pkg::QREG_WIDTH-1:0]      i_cfg_data,
    qvr_vec_if.sink                                  i_vec,
    qvr_rot_if.source                                o_rot
);
    import qvr_pkg::*;

    localparam int F  = QUAT_FRAC_BITS;
    localparam int CW = COORD_WIDTH;
    localparam int MW = MAT_WIDTH;
    localparam int QW = (F + 2 > QREG_WIDTH) ? F + 2 : QREG_WIDTH;
    localparam int PW = QW + QREG_WIDTH;
    localparam int EW = ((PW + 3 > 2 * F + 3) ? PW + 3 : 2 * F + 3) + 1;
    localparam int PRW = MW + CW;
    localparam int SW = ((PRW + 2 > F + 1) ? PRW + 2 : F + 1) + 1;

    localparam logic signed [QW-1:0] C_W_ONE = {{(QW - F - 1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [EW-1:0] C_E_ONE =
        {{(EW - 2 * F - 1){1'b0}}, 1'b1, {(2 * F){1'b0}}};
    localparam logic signed [EW-1:0] C_E_HALF = {{(EW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic signed [EW-1:0] C_E_HI = {{(EW - MW + 1){1'b0}}, {(MW - 1){1'b1}}};
    localparam logic signed [EW-1:0] C_E_LO = ~C_E_HI;
    localparam logic signed [MW-1:0] C_M_HI = {1'b0, {(MW - 1){1'b1}}};
    localparam logic signed [MW-1:0] C_M_LO = ~C_M_HI;
    localparam logic signed [MW-1:0] C_DIAG =
        (F < MW - 1) ? MW'(1 << F) : C_M_HI;
    localparam logic signed [SW-1:0] C_S_HALF = {{(SW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic signed [SW-1:0] C_S_HI = {{(SW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
    localparam logic signed [SW-1:0] C_S_LO = ~C_S_HI;
    localparam logic signed [CW-1:0] C_C_HI = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0] C_C_LO = ~C_C_HI;

    // Round one matrix entry to the stored fraction and clip it to the entry width.
    function automatic logic signed [MW-1:0] f_entry(input logic signed [EW-1:0] e);
        logic signed [EW-1:0] t;
        t = (e + C_E_HALF) >>> F;
        if (t > C_E_HI) begin
            return C_M_HI;
        end else if (t < C_E_LO) begin
            return C_M_LO;
        end
        return t[MW-1:0];
    endfunction

    // Quaternion registers.
    logic signed [QREG_WIDTH-1:0] r_qx, r_qy, r_qz;
    logic signed [QW-1:0]         r_qw;

    // Rebuild sequencer state and component products.
    logic                         r_busy;
    t_step                        r_step;
    logic signed [PW-1:0]         r_prod [MAT_ENTRIES];
    logic signed [QW-1:0]         w_qa;
    logic signed [QREG_WIDTH-1:0] w_qb;
    logic signed [EW-1:0]         w_pe [MAT_ENTRIES];
    logic signed [MW-1:0]         n_mat [MAT_ENTRIES];
    logic signed [MW-1:0]         r_mat [MAT_ENTRIES];

    // Quaternion register writes; any write restarts the rebuild.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
            r_qw <= C_W_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QUAT_X: r_qx <= i_cfg_data;
                CFG_QUAT_Y: r_qy <= i_cfg_data;
                CFG_QUAT_Z: r_qz <= i_cfg_data;
                CFG_QUAT_W: r_qw <= QW'($signed(i_cfg_data));
                default:    r_qw <= r_qw;
            endcase
        end
    end

    // Operand selection for the shared multiplier, one product per step.
    always_comb begin
        unique case (r_step)
            P_XX:    begin w_qa = QW'(r_qx); w_qb = r_qx; end
            P_YY:    begin w_qa = QW'(r_qy); w_qb = r_qy; end
            P_ZZ:    begin w_qa = QW'(r_qz); w_qb = r_qz; end
            P_XY:    begin w_qa = QW'(r_qx); w_qb = r_qy; end
            P_XZ:    begin w_qa = QW'(r_qx); w_qb = r_qz; end
            P_YZ:    begin w_qa = QW'(r_qy); w_qb = r_qz; end
            P_WX:    begin w_qa = r_qw;      w_qb = r_qx; end
            P_WY:    begin w_qa = r_qw;      w_qb = r_qy; end
            P_WZ:    begin w_qa = r_qw;      w_qb = r_qz; end
            default: begin w_qa = '0;        w_qb = '0;   end
        endcase
    end

    // Doubled products and the nine entries of the standard formula.
    always_comb begin
        for (int i = 0; i < MAT_ENTRIES; i++) begin
            w_pe[i] = EW'(r_prod[i]) <<< 1;
        end
        n_mat[0] = f_entry(C_E_ONE - w_pe[P_YY] - w_pe[P_ZZ]);
        n_mat[1] = f_entry(w_pe[P_XY] - w_pe[P_WZ]);
        n_mat[2] = f_entry(w_pe[P_XZ] + w_pe[P_WY]);
        n_mat[3] = f_entry(w_pe[P_XY] + w_pe[P_WZ]);
        n_mat[4] = f_entry(C_E_ONE - w_pe[P_XX] - w_pe[P_ZZ]);
        n_mat[5] = f_entry(w_pe[P_YZ] - w_pe[P_WX]);
        n_mat[6] = f_entry(w_pe[P_XZ] - w_pe[P_WY]);
        n_mat[7] = f_entry(w_pe[P_YZ] + w_pe[P_WX]);
        n_mat[8] = f_entry(C_E_ONE - w_pe[P_XX] - w_pe[P_YY]);
    end

    // Rebuild sequencer: nine product steps, then the matrix is loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= P_XX;
        end else if (i_cfg_we) begin
            r_busy <= 1'b1;
            r_step <= P_XX;
        end else if (r_busy) begin
            if (r_step == P_DONE) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && r_step != P_DONE) begin
            r_prod[r_step] <= w_qa * w_qb;
        end
    end

    // Matrix register, identity at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAT_ENTRIES; i++) begin
                r_mat[i] <= (i % 4 == 0) ? C_DIAG : '0;
            end
        end else if (r_busy && !i_cfg_we && r_step == P_DONE) begin
            r_mat <= n_mat;
        end
    end

    // Pipeline control: every stage moves when the output register is free.
    logic r_v1, r_v2, r_v3;
    logic w_adv;
    logic w_in_acc;

    assign w_adv       = !r_v3 || o_rot.ready;
    assign i_vec.ready = w_adv && !r_busy && !i_cfg_we;
    assign w_in_acc    = i_vec.valid && i_vec.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_in_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage one: the nine entry-by-coordinate products.
    logic signed [CW-1:0]  w_vec [3];
    logic signed [PRW-1:0] r_p [MAT_ENTRIES];

    assign w_vec[0] = i_vec.vec_x;
    assign w_vec[1] = i_vec.vec_y;
    assign w_vec[2] = i_vec.vec_z;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < MAT_ENTRIES; i++) begin
                r_p[i] <= r_mat[i] * w_vec[i % 3];
            end
        end
    end

    // Stage two: row sums with the rounding half added.
    logic signed [SW-1:0] r_s [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_s[r] <= SW'(r_p[3 * r]) + SW'(r_p[3 * r + 1]) + SW'(r_p[3 * r + 2])
                          + C_S_HALF;
            end
        end
    end

    // Stage three: drop the fraction, saturate and load the output register.
    logic signed [SW-1:0] w_sh [3];
    logic signed [CW-1:0] n_rot [3];
    logic [2:0]           w_hit;
    logic signed [CW-1:0] r_rot [3];
    logic                 r_sat;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sh[r] = r_s[r] >>> F;
            if (w_sh[r] > C_S_HI) begin
                n_rot[r] = C_C_HI;
                w_hit[r] = 1'b1;
            end else if (w_sh[r] < C_S_LO) begin
                n_rot[r] = C_C_LO;
                w_hit[r] = 1'b1;
            end else begin
                n_rot[r] = w_sh[r][CW-1:0];
                w_hit[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rot <= n_rot;
            r_sat <= |w_hit;
        end
    end

    assign o_rot.valid     = r_v3;
    assign o_rot.rot_x     = r_rot[0];
    assign o_rot.rot_y     = r_rot[1];
    assign o_rot.rot_z     = r_rot[2];
    assign o_rot.saturated = r_sat;

endmodule

`default_nettype wire
